>>> sv/pmfl_pkg.sv
// Shared constants and command types for the paged memory block.
`timescale 1ns / 1ps
package pmfl_pkg;

  localparam int NUM_VPAGES = 16;
  localparam int PAGE_WORDS = 8;
  localparam int VPAGE_W    = 4;
  localparam int OFFSET_W   = 3;
  localparam int VADDR_W    = VPAGE_W + OFFSET_W;
  localparam int STAMP_W    = 32;

  typedef struct packed {
    logic rd;
    logic wr;
    logic set_valid;
    logic clr_valid;
  } pt_cmd_t;

  typedef struct packed {
    logic fill_start;
    logic rd;
    logic wr;
  } fs_cmd_t;

endpackage

>>> sv/paged_memory_fifo_lru_replacement.sv
// Paged memory top level: request sequencer with FIFO/LRU victim search over the page table.
// A hit passes lookup, access and response; a fault on a free frame adds the frame refill.
// A fault with eviction adds a stamp scan over all NUM_VPAGES pages before the refill.
// One request in flight; the response waits while out_tready stalls.
// Synchronous active-low reset clears valid bits and the free and scan counters.
// The stamp resets to 1; there is no clearing pass after reset.
`timescale 1ns / 1ps
module paged_memory_fifo_lru_replacement #(
  parameter int  DATA_WIDTH = 32,
  parameter int  NUM_FRAMES = 4,
  localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  // vaddr, wdata
  input  logic [((pmfl_pkg::VADDR_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // req_type
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // rdata, page_fault, evicted, victim_page, frame_used
  output logic [((DATA_WIDTH + 2 + pmfl_pkg::VPAGE_W + FRAME_W + 7) / 8) * 8 - 1:0] out_tdata
);
  import pmfl_pkg::*;

  localparam int OUT_W  = ((DATA_WIDTH + 2 + VPAGE_W + FRAME_W + 7) / 8) * 8;
  localparam int FCNT_W = $clog2(NUM_FRAMES + 1);
  localparam int SCNT_W = VPAGE_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOKUP = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_ACCESS = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic                  is_wr_r, is_wr_nxt;
  logic [VPAGE_W-1:0]    page_r, page_nxt;
  logic [OFFSET_W-1:0]   offset_r, offset_nxt;
  logic [DATA_WIDTH-1:0] wdata_r, wdata_nxt;
  logic                  fault_r, fault_nxt;
  logic                  evicted_r, evicted_nxt;
  logic [VPAGE_W-1:0]    victim_r, victim_nxt;
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic [SCNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [VPAGE_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                  scan_pend_r, scan_pend_nxt;
  logic                  found_r, found_nxt;
  logic [VPAGE_W-1:0]    best_page_r, best_page_nxt;
  logic [STAMP_W-1:0]    best_stamp_r, best_stamp_nxt;
  logic [FRAME_W-1:0]    best_frame_r, best_frame_nxt;
  logic [FCNT_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [STAMP_W-1:0]    stamp_r, stamp_nxt;
  logic                  policy_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  pt_cmd_t               pt_cmd;
  logic [VPAGE_W-1:0]    pt_rd_page;
  logic [FRAME_W-1:0]    pt_wr_frame;
  logic [FRAME_W-1:0]    pt_rd_frame;
  logic [STAMP_W-1:0]    pt_rd_stamp;
  logic                  pt_rd_valid;
  fs_cmd_t               fs_cmd;
  logic [DATA_WIDTH-1:0] fs_rdata;
  logic                  fs_fill_done;
  logic [DATA_WIDTH-1:0] resp_data;
  logic                  in_xfer;
  logic                  scan_issue;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign scan_issue = !scan_cnt_r[VPAGE_W];

  always_comb begin
    if (is_wr_r) begin
      resp_data = '0;
    end else if (fault_r) begin
      resp_data = {DATA_WIDTH{1'b1}};
    end else begin
      resp_data = fs_rdata;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    is_wr_nxt      = is_wr_r;
    page_nxt       = page_r;
    offset_nxt     = offset_r;
    wdata_nxt      = wdata_r;
    fault_nxt      = fault_r;
    evicted_nxt    = evicted_r;
    victim_nxt     = victim_r;
    frame_nxt      = frame_r;
    scan_cnt_nxt   = scan_cnt_r;
    scan_idx_nxt   = scan_idx_r;
    scan_pend_nxt  = scan_pend_r;
    found_nxt      = found_r;
    best_page_nxt  = best_page_r;
    best_stamp_nxt = best_stamp_r;
    best_frame_nxt = best_frame_r;
    free_cnt_nxt   = free_cnt_r;
    stamp_nxt      = stamp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    pt_cmd         = '0;
    pt_rd_page     = in_tdata[VADDR_W-1:OFFSET_W];
    pt_wr_frame    = frame_r;
    fs_cmd         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          is_wr_nxt   = in_tuser;
          page_nxt    = in_tdata[VADDR_W-1:OFFSET_W];
          offset_nxt  = in_tdata[OFFSET_W-1:0];
          wdata_nxt   = in_tdata[VADDR_W +: DATA_WIDTH];
          fault_nxt   = 1'b0;
          evicted_nxt = 1'b0;
          victim_nxt  = '0;
          pt_cmd.rd   = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (pt_rd_valid) begin
          frame_nxt = pt_rd_frame;
          if (policy_r) begin
            pt_wr_frame = pt_rd_frame;
            pt_cmd.wr   = 1'b1;
            stamp_nxt   = stamp_r + 1'b1;
          end
          state_nxt = S_ACCESS;
        end else begin
          fault_nxt = 1'b1;
          if (free_cnt_r < FCNT_W'(NUM_FRAMES)) begin
            frame_nxt         = FRAME_W'(free_cnt_r);
            free_cnt_nxt      = free_cnt_r + 1'b1;
            fs_cmd.fill_start = 1'b1;
            state_nxt         = S_FILL;
          end else begin
            scan_cnt_nxt  = '0;
            scan_pend_nxt = 1'b0;
            found_nxt     = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        pt_rd_page    = scan_cnt_r[VPAGE_W-1:0];
        pt_cmd.rd     = scan_issue;
        scan_pend_nxt = scan_issue;
        if (scan_issue) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          scan_idx_nxt = scan_cnt_r[VPAGE_W-1:0];
        end
        // strict compare keeps the lowest page on equal stamps
        if (scan_pend_r && pt_rd_valid && (!found_r || (pt_rd_stamp < best_stamp_r))) begin
          found_nxt      = 1'b1;
          best_page_nxt  = scan_idx_r;
          best_stamp_nxt = pt_rd_stamp;
          best_frame_nxt = pt_rd_frame;
        end
        if (!scan_issue && !scan_pend_r) begin
          if (found_r) begin
            evicted_nxt      = 1'b1;
            victim_nxt       = best_page_r;
            frame_nxt        = best_frame_r;
            pt_cmd.clr_valid = 1'b1;
          end else begin
            frame_nxt = '0;
          end
          fs_cmd.fill_start = 1'b1;
          state_nxt         = S_FILL;
        end
      end
      S_FILL: begin
        if (fs_fill_done) begin
          pt_cmd.wr        = 1'b1;
          pt_cmd.set_valid = 1'b1;
          stamp_nxt        = stamp_r + 1'b1;
          state_nxt        = S_ACCESS;
        end
      end
      S_ACCESS: begin
        fs_cmd.wr = is_wr_r;
        fs_cmd.rd = !is_wr_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({frame_r, victim_r, evicted_r, fault_r, resp_data});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= '0;
      stamp_r     <= STAMP_W'(1);
      policy_r    <= 1'b0;
      out_valid_r <= 1'b0;
      scan_cnt_r  <= '0;
      scan_pend_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      scan_pend_r <= scan_pend_nxt;
      found_r     <= found_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_wr_r      <= is_wr_nxt;
    page_r       <= page_nxt;
    offset_r     <= offset_nxt;
    wdata_r      <= wdata_nxt;
    fault_r      <= fault_nxt;
    evicted_r    <= evicted_nxt;
    victim_r     <= victim_nxt;
    frame_r      <= frame_nxt;
    scan_idx_r   <= scan_idx_nxt;
    best_page_r  <= best_page_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_frame_r <= best_frame_nxt;
    out_data_r   <= out_data_nxt;
  end

  pmfl_page_table #(
    .FRAME_W (FRAME_W)
  ) u_page_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (pt_cmd),
    .rd_page  (pt_rd_page),
    .wr_page  (page_r),
    .clr_page (best_page_r),
    .wr_frame (pt_wr_frame),
    .wr_stamp (stamp_r),
    .rd_frame (pt_rd_frame),
    .rd_stamp (pt_rd_stamp),
    .rd_valid (pt_rd_valid)
  );

  // frame_nxt carries the new frame at fill start and equals frame_r during access
  pmfl_frame_store #(
    .NUM_FRAMES (NUM_FRAMES),
    .FRAME_W    (FRAME_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_frame_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fs_cmd),
    .frame     (frame_nxt),
    .offset    (offset_r),
    .wdata     (wdata_r),
    .rdata     (fs_rdata),
    .fill_done (fs_fill_done)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> sv/pmfl_page_table.sv
// Page table: valid bits in flops, frame and stamp per page in a synchronous memory.
`timescale 1ns / 1ps
module pmfl_page_table #(
  parameter int FRAME_W = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmfl_pkg::pt_cmd_t             cmd,
  input  logic [pmfl_pkg::VPAGE_W-1:0]  rd_page,
  input  logic [pmfl_pkg::VPAGE_W-1:0]  wr_page,
  input  logic [pmfl_pkg::VPAGE_W-1:0]  clr_page,
  input  logic [FRAME_W-1:0]            wr_frame,
  input  logic [pmfl_pkg::STAMP_W-1:0]  wr_stamp,
  output logic [FRAME_W-1:0]            rd_frame,
  output logic [pmfl_pkg::STAMP_W-1:0]  rd_stamp,
  output logic                          rd_valid
);
  import pmfl_pkg::*;

  logic [NUM_VPAGES-1:0] valid_r;
  logic [FRAME_W-1:0]    frame_mem [0:NUM_VPAGES-1];
  logic [STAMP_W-1:0]    stamp_mem [0:NUM_VPAGES-1];
  logic [FRAME_W-1:0]    rd_frame_r;
  logic [STAMP_W-1:0]    rd_stamp_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      frame_mem[wr_page] <= wr_frame;
      stamp_mem[wr_page] <= wr_stamp;
    end
    if (cmd.rd) begin
      rd_frame_r <= frame_mem[rd_page];
      rd_stamp_r <= stamp_mem[rd_page];
      rd_valid_r <= valid_r[rd_page];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.clr_valid) begin
        valid_r[clr_page] <= 1'b0;
      end
      if (cmd.set_valid) begin
        valid_r[wr_page] <= 1'b1;
      end
    end
  end

  assign rd_frame = rd_frame_r;
  assign rd_stamp = rd_stamp_r;
  assign rd_valid = rd_valid_r;

endmodule

>>> sv/pmfl_frame_store.sv
// Physical frame store with a one-word-per-cycle refill sweep of a whole frame.
`timescale 1ns / 1ps
module pmfl_frame_store #(
  parameter int NUM_FRAMES = 4,
  parameter int FRAME_W    = 2,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmfl_pkg::fs_cmd_t             cmd,
  input  logic [FRAME_W-1:0]            frame,
  input  logic [pmfl_pkg::OFFSET_W-1:0] offset,
  input  logic [DATA_WIDTH-1:0]         wdata,
  output logic [DATA_WIDTH-1:0]         rdata,
  output logic                          fill_done
);
  import pmfl_pkg::*;

  localparam int DEPTH  = NUM_FRAMES * PAGE_WORDS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem [0:DEPTH-1];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  fill_busy_r;
  logic [OFFSET_W-1:0]   fill_cnt_r;
  logic [FRAME_W-1:0]    fill_frame_r;
  logic [ADDR_W-1:0]     acc_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_en;

  assign fill_done = fill_busy_r && (fill_cnt_r == OFFSET_W'(PAGE_WORDS - 1));
  assign acc_addr  = ADDR_W'({frame, offset});
  assign wr_addr   = fill_busy_r ? ADDR_W'({fill_frame_r, fill_cnt_r}) : acc_addr;
  assign wr_data   = fill_busy_r ? {DATA_WIDTH{1'b1}} : wdata;
  assign wr_en     = fill_busy_r || cmd.wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= mem[acc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      fill_cnt_r   <= '0;
      fill_frame_r <= frame;
    end else if (fill_busy_r) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b0;
    end else if (cmd.fill_start) begin
      fill_busy_r <= 1'b1;
    end else if (fill_done) begin
      fill_busy_r <= 1'b0;
    end
  end

  assign rdata = rdata_r;

endmodule
